### rtl/tscm_pkg.sv
package tscm_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int ANGLE_W  = 8;
  localparam int ANG_W    = 10;   // internal signed angle width
  localparam int SLOPE_W  = 32;   // q16.16 slope
  localparam int DIFF_W   = 11;   // signed end-to-end angle difference
  localparam int DMAG_W   = 10;   // magnitude of that difference
  localparam int SPAN_W   = 13;   // signed pedal span
  localparam int DIV_W    = DMAG_W + 16;  // dividend and quotient width
  localparam int CNT_W    = $clog2(DIV_W);
  localparam int PROD_W   = 45;   // slope times pedal offset, plus intercept
  localparam int FRAC_W   = 16;

  // apb register map
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_PEDAL_MIN     = 3'd0;
  localparam logic [2:0] REG_PEDAL_MAX     = 3'd1;
  localparam logic [2:0] REG_TPS_MIN       = 3'd2;
  localparam logic [2:0] REG_TPS_MAX       = 3'd3;
  localparam logic [2:0] REG_INITIAL_ANGLE = 3'd4;
  localparam logic [2:0] REG_SWEEP_REVERSE = 3'd5;

  // register reset values
  localparam logic [SAMPLE_W-1:0] PEDAL_MIN_RST = 12'd0;
  localparam logic [SAMPLE_W-1:0] PEDAL_MAX_RST = 12'd4095;
  localparam logic [SAMPLE_W-1:0] TPS_MIN_RST   = 12'd0;
  localparam logic [SAMPLE_W-1:0] TPS_MAX_RST   = 12'd4095;
  localparam logic [ANGLE_W-1:0]  INIT_ANG_RST  = 8'd90;

  localparam logic [ANGLE_W-1:0] ANGLE_SAT = 8'd180;

  typedef enum logic [1:0] {
    MODE_SWEEP_LO = 2'd0,
    MODE_SWEEP_HI = 2'd1,
    MODE_RUN      = 2'd2
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pedal_min;
    logic [SAMPLE_W-1:0] pedal_max;
    logic [SAMPLE_W-1:0] tps_min;
    logic [SAMPLE_W-1:0] tps_max;
    logic [ANGLE_W-1:0]  initial_angle;
    logic                sweep_reverse;
  } cfg_regs_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic div_done;
    logic mul;
    logic map;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_go;
    logic map_go;
    logic div_last;
  } dp_sts_t;

endpackage

### rtl/tscm_regs.sv
module tscm_regs
  import tscm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  cfg_regs_t   cfg_r;
  cfg_regs_t   cfg_nxt;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PEDAL_MIN:     cfg_nxt.pedal_min     = pwdata[SAMPLE_W-1:0];
        REG_PEDAL_MAX:     cfg_nxt.pedal_max     = pwdata[SAMPLE_W-1:0];
        REG_TPS_MIN:       cfg_nxt.tps_min       = pwdata[SAMPLE_W-1:0];
        REG_TPS_MAX:       cfg_nxt.tps_max       = pwdata[SAMPLE_W-1:0];
        REG_INITIAL_ANGLE: cfg_nxt.initial_angle = pwdata[ANGLE_W-1:0];
        REG_SWEEP_REVERSE: cfg_nxt.sweep_reverse = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PEDAL_MIN:     prdata = CFG_DW'(cfg_r.pedal_min);
      REG_PEDAL_MAX:     prdata = CFG_DW'(cfg_r.pedal_max);
      REG_TPS_MIN:       prdata = CFG_DW'(cfg_r.tps_min);
      REG_TPS_MAX:       prdata = CFG_DW'(cfg_r.tps_max);
      REG_INITIAL_ANGLE: prdata = CFG_DW'(cfg_r.initial_angle);
      REG_SWEEP_REVERSE: prdata = CFG_DW'(cfg_r.sweep_reverse);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pedal_min     <= PEDAL_MIN_RST;
      cfg_r.pedal_max     <= PEDAL_MAX_RST;
      cfg_r.tps_min       <= TPS_MIN_RST;
      cfg_r.tps_max       <= TPS_MAX_RST;
      cfg_r.initial_angle <= INIT_ANG_RST;
      cfg_r.sweep_reverse <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/tscm_ctrl.sv
module tscm_ctrl
  import tscm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_DFIN = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_MAP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.div_go) begin
          state_nxt = S_DIV;
        end else if (sts.map_go) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_done = 1'b1;
        state_nxt    = S_DONE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/tscm_dp.sv
module tscm_dp
  import tscm_pkg::*;
#(
  parameter int ANGLE_LIMIT_LOW  = 0,
  parameter int ANGLE_LIMIT_HIGH = 180,
  parameter int AMEND_DEGREES    = 2,
  parameter int SAMPLE_BITS      = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_regs_t           cfg,
  input  logic                in_func,
  input  logic [SAMPLE_W-1:0] in_tps_sample,
  input  logic [SAMPLE_W-1:0] in_target_position,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [ANGLE_W-1:0]  out_servo_angle,
  output logic [1:0]          out_phase,
  output logic                out_span_error
);

  localparam logic signed [ANG_W:0] LIM_LO = (ANG_W+1)'(ANGLE_LIMIT_LOW);
  localparam logic signed [ANG_W:0] LIM_HI = (ANG_W+1)'(ANGLE_LIMIT_HIGH);
  localparam logic signed [ANG_W:0] AMEND  = (ANG_W+1)'(AMEND_DEGREES + 1);

  // captured item
  logic                func_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [SAMPLE_W-1:0] tgt_r;

  // calibration state
  logic signed [ANG_W-1:0]   cur_r,   cur_nxt;
  mode_t                     mode_r,  mode_nxt;
  logic signed [ANG_W-1:0]   low_r,   low_nxt;
  logic signed [ANG_W-1:0]   high_r,  high_nxt;
  logic signed [SLOPE_W-1:0] slope_r, slope_nxt;
  logic                      zspan_r, zspan_nxt;

  // divider
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic signed [PROD_W-1:0] prod_r;

  logic [ANGLE_W-1:0] angle_out_r;
  logic [1:0]         phase_out_r;
  logic               span_out_r;

  logic [SAMPLE_W-1:0]      smask;
  logic [SAMPLE_W-1:0]      samp_m, tgt_m;
  logic                     hit_lo, hit_hi;
  logic signed [ANG_W:0]    cur_x, step_back, step_fwd, low_new, high_new;
  logic signed [DIFF_W-1:0] diff;
  logic [DMAG_W-1:0]        diff_mag;
  logic signed [SPAN_W-1:0] span;
  logic [SAMPLE_W-1:0]      span_mag;
  logic [SAMPLE_W:0]        rem_sh;
  logic                     rem_ge;
  logic [SLOPE_W-1:0]       q_ext;
  logic signed [SPAN_W-1:0] doff;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-FRAC_W-1:0] a_trunc;
  logic [ANGLE_W-1:0]       mapped;
  logic [ANGLE_W-1:0]       shown;

  function automatic logic signed [ANG_W:0] clamp_ang(input logic signed [ANG_W:0] v);
    logic signed [ANG_W:0] r;
    r = v;
    if (v < LIM_LO) r = LIM_LO;
    if (v > LIM_HI) r = LIM_HI;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      smask[i] = (i < SAMPLE_BITS);
    end
  end

  assign samp_m = samp_r & smask;
  assign tgt_m  = tgt_r & smask;
  assign hit_lo = samp_m < cfg.tps_min;
  assign hit_hi = samp_m > cfg.tps_max;

  // one degree steps against / along the servo direction, and the end positions offset by the amend
  assign cur_x     = {cur_r[ANG_W-1], cur_r};
  assign step_back = cfg.sweep_reverse ? cur_x + 2'sd1 : cur_x - 2'sd1;
  assign step_fwd  = cfg.sweep_reverse ? cur_x - 2'sd1 : cur_x + 2'sd1;
  assign low_new   = cfg.sweep_reverse ? cur_x - AMEND : cur_x + AMEND;
  assign high_new  = cfg.sweep_reverse ? cur_x + AMEND : cur_x - AMEND;

  assign diff     = DIFF_W'(high_new) - DIFF_W'(low_r);
  assign diff_mag = diff[DIFF_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
  assign span     = $signed({1'b0, cfg.pedal_max}) - $signed({1'b0, cfg.pedal_min});
  assign span_mag = span[SPAN_W-1] ? SAMPLE_W'(-span) : SAMPLE_W'(span);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};
  assign q_ext  = SLOPE_W'(quo_r);

  // mapping: slope times pedal offset, then intercept and truncate toward zero
  assign doff   = $signed({1'b0, tgt_m}) - $signed({1'b0, cfg.pedal_min});
  assign prod_c = slope_r * doff;
  assign acc    = (PROD_W'(low_r) <<< FRAC_W) + prod_r;

  always_comb begin
    a_trunc = acc[PROD_W-1:FRAC_W];
    if (acc[PROD_W-1] && (acc[FRAC_W-1:0] != '0)) begin
      a_trunc = a_trunc + 2'sd1;
    end
    if (a_trunc[PROD_W-FRAC_W-1]) begin
      mapped = '0;
    end else if (a_trunc > $signed({1'b0, ANGLE_SAT})) begin
      mapped = ANGLE_SAT;
    end else begin
      mapped = a_trunc[ANGLE_W-1:0];
    end
  end

  assign sts.div_go   = !func_r && (mode_r == MODE_SWEEP_HI) && hit_hi && (span != '0);
  assign sts.map_go   = !func_r && (mode_r != MODE_SWEEP_LO) && (mode_r != MODE_SWEEP_HI);
  assign sts.div_last = (cnt_r == '0);

  always_comb begin
    cur_nxt   = cur_r;
    mode_nxt  = mode_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    slope_nxt = slope_r;
    zspan_nxt = zspan_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;

    if (cmd.eval) begin
      if (func_r) begin
        cur_nxt   = ANG_W'(cfg.initial_angle);
        mode_nxt  = MODE_SWEEP_LO;
        zspan_nxt = 1'b0;
      end else begin
        unique case (mode_r)
          MODE_SWEEP_LO: begin
            if (hit_lo) begin
              low_nxt  = low_new[ANG_W-1:0];
              mode_nxt = MODE_SWEEP_HI;
            end else begin
              cur_nxt = ANG_W'(clamp_ang(step_back));
            end
          end
          MODE_SWEEP_HI: begin
            if (hit_hi) begin
              high_nxt = high_new[ANG_W-1:0];
              if (span == '0) begin
                slope_nxt = '0;
                zspan_nxt = 1'b1;
                mode_nxt  = MODE_RUN;
              end else begin
                quo_nxt = {diff_mag, FRAC_W'(0)};
                rem_nxt = '0;
                den_nxt = span_mag;
                neg_nxt = diff[DIFF_W-1] ^ span[SPAN_W-1];
                cnt_nxt = CNT_W'(DIV_W - 1);
              end
            end else begin
              cur_nxt = ANG_W'(clamp_ang(step_fwd));
            end
          end
          default: mode_nxt = MODE_RUN;
        endcase
      end
    end

    if (cmd.div_step) begin
      rem_nxt = rem_ge ? SAMPLE_W'(rem_sh - {1'b0, den_r}) : SAMPLE_W'(rem_sh);
      quo_nxt = {quo_r[DIV_W-2:0], rem_ge};
      cnt_nxt = cnt_r - 1'b1;
    end

    if (cmd.div_done) begin
      slope_nxt = neg_r ? -$signed(q_ext) : $signed(q_ext);
      zspan_nxt = 1'b0;
      mode_nxt  = MODE_RUN;
    end

    if (cmd.map) begin
      cur_nxt  = ANG_W'(mapped);
      mode_nxt = MODE_RUN;
    end
  end

  assign shown = cur_r[ANG_W-1] ? '0 :
                 (cur_r > $signed({2'b00, ANGLE_SAT})) ? ANGLE_SAT : cur_r[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= ANG_W'(INIT_ANG_RST);
      mode_r  <= MODE_SWEEP_LO;
      low_r   <= '0;
      high_r  <= '0;
      slope_r <= '0;
      zspan_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cur_r   <= cur_nxt;
      mode_r  <= mode_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      slope_r <= slope_nxt;
      zspan_r <= zspan_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      samp_r <= in_tps_sample;
      tgt_r  <= in_target_position;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.load_out) begin
      angle_out_r <= shown;
      phase_out_r <= mode_r;
      span_out_r  <= zspan_r;
    end
  end

  assign out_servo_angle = angle_out_r;
  assign out_phase       = phase_out_r;
  assign out_span_error  = span_out_r;

endmodule

### rtl/throttle_servo_calibrate_and_map.sv
// throttle servo calibration and mapping. every input beat is one servo tick and
// produces exactly one output beat (angle, phase, span error). func=1 restarts
// calibration at initial_angle; the block then sweeps the angle one degree per
// tick toward the closed end until the sample drops below tps_min, records the
// low end, sweeps back until the sample exceeds tps_max, records the high end
// and derives a q16.16 slope; after that each tick maps target_position linearly
// onto the recorded range, saturated to 0..180. a restart or sweep tick goes from
// accept through evaluate to output load; a running tick adds a multiply step and
// an add/round step, and the tick that closes calibration with a nonzero pedal
// span runs the restoring slope divider, which retires one quotient bit per
// cycle over 26 bits. only one tick is in flight at a time; the next
// beat is accepted while the previous result still waits in the output register.
// registers are written over apb at byte address 4*index and read back there;
// write them only while the block is idle.
module throttle_servo_calibrate_and_map
  import tscm_pkg::*;
#(
  parameter int ANGLE_LIMIT_LOW  = 0,
  parameter int ANGLE_LIMIT_HIGH = 180,
  parameter int AMEND_DEGREES    = 2,
  parameter int SAMPLE_BITS      = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  // apb register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready,
  // tick input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [SAMPLE_W-1:0] in_tps_sample,
  input  logic [SAMPLE_W-1:0] in_target_position,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ANGLE_W-1:0]  out_servo_angle,
  output logic [1:0]          out_phase,
  output logic                out_span_error
);

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  // configuration registers
  tscm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: accept, evaluate, then divide, multiply/map or neither, then load output
  tscm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // calibration state, slope divider, mapping multiplier and output register
  tscm_dp #(
    .ANGLE_LIMIT_LOW  (ANGLE_LIMIT_LOW),
    .ANGLE_LIMIT_HIGH (ANGLE_LIMIT_HIGH),
    .AMEND_DEGREES    (AMEND_DEGREES),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_func            (in_func),
    .in_tps_sample      (in_tps_sample),
    .in_target_position (in_target_position),
    .cmd                (cmd),
    .sts                (sts),
    .out_servo_angle    (out_servo_angle),
    .out_phase          (out_phase),
    .out_span_error     (out_span_error)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tscm_pkg::*;

  // block parameters, kept equal to the ones passed to the instance
  localparam int ANGLE_LO = 0;
  localparam int ANGLE_HI = 180;
  localparam int AMEND    = 2;

  localparam int Q16_ONE        = 65536;
  localparam int SAMPLE_MAX     = 4095;
  localparam int ANGLE_REG_MAX  = 255;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;

  // tick function codes
  localparam bit FUNC_TICK    = 1'b0;
  localparam bit FUNC_RESTART = 1'b1;

  // one servo command as it leaves the block
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [1:0]         phase;
    logic               span_err;
  } servo_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = 1'b0;
  logic [SAMPLE_W-1:0] in_tps_sample = '0;
  logic [SAMPLE_W-1:0] in_target_position = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ANGLE_W-1:0]  out_servo_angle;
  logic [1:0]          out_phase;
  logic                out_span_error;

  // commands predicted for accepted ticks, oldest first
  servo_cmd_t pending_cmds[$];

  // shadow of the register file and of the calibration state
  cfg_regs_t cfg_shadow;
  int        model_angle;
  mode_t     model_mode;
  int        low_end;
  int        high_end;
  int        slope_q16;
  bit        model_zero_span;

  int errors = 0;
  int ticks_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // receiver hold-off: the test bumps hold_req, the ready process does the counting
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  throttle_servo_calibrate_and_map #(
    .ANGLE_LIMIT_LOW (ANGLE_LO),
    .ANGLE_LIMIT_HIGH(ANGLE_HI),
    .AMEND_DEGREES   (AMEND),
    .SAMPLE_BITS     (SAMPLE_W)
  ) dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the calibration state by one tick and return the command it shows
  function automatic servo_cmd_t servo_tick(bit func, logic [SAMPLE_W-1:0] sample,
                                            logic [SAMPLE_W-1:0] target);
    int         dir;
    int         span;
    longint     offset;
    longint     acc;
    servo_cmd_t cmd;
    dir = cfg_shadow.sweep_reverse ? -1 : 1;
    if (func == FUNC_RESTART) begin
      // restart keeps the recorded ends and the slope
      model_angle     = int'(cfg_shadow.initial_angle);
      model_mode      = MODE_SWEEP_LO;
      model_zero_span = 1'b0;
    end else begin
      case (model_mode)
        MODE_SWEEP_LO: begin
          if (sample < cfg_shadow.tps_min) begin
            low_end    = model_angle + dir * (1 + AMEND);
            model_mode = MODE_SWEEP_HI;
          end else begin
            model_angle = clamp_int(model_angle - dir, ANGLE_LO, ANGLE_HI);
          end
        end
        MODE_SWEEP_HI: begin
          if (sample > cfg_shadow.tps_max) begin
            high_end = model_angle - dir * (1 + AMEND);
            span     = int'(cfg_shadow.pedal_max) - int'(cfg_shadow.pedal_min);
            if (span == 0) begin
              slope_q16       = 0;
              model_zero_span = 1'b1;
            end else begin
              // signed division truncates toward zero
              slope_q16       = int'(longint'(high_end - low_end) * Q16_ONE / span);
              model_zero_span = 1'b0;
            end
            model_mode = MODE_RUN;
          end else begin
            model_angle = clamp_int(model_angle + dir, ANGLE_LO, ANGLE_HI);
          end
        end
        default: begin
          // line through the low end at pedal_min, q16.16 slope
          offset      = longint'(target) - longint'(cfg_shadow.pedal_min);
          acc         = longint'(low_end) * Q16_ONE + longint'(slope_q16) * offset;
          model_angle = clamp_int(int'(acc / Q16_ONE), 0, int'(ANGLE_SAT));
          model_mode  = MODE_RUN;
        end
      endcase
    end
    cmd.angle    = ANGLE_W'(clamp_int(model_angle, 0, int'(ANGLE_SAT)));
    cmd.phase    = model_mode;
    cmd.span_err = model_zero_span;
    return cmd;
  endfunction

  task automatic reset_model();
    cfg_shadow.pedal_min     = PEDAL_MIN_RST;
    cfg_shadow.pedal_max     = PEDAL_MAX_RST;
    cfg_shadow.tps_min       = TPS_MIN_RST;
    cfg_shadow.tps_max       = TPS_MAX_RST;
    cfg_shadow.initial_angle = INIT_ANG_RST;
    cfg_shadow.sweep_reverse = 1'b0;
    model_angle     = int'(INIT_ANG_RST);
    model_mode      = MODE_SWEEP_LO;
    low_end         = 0;
    high_end        = 0;
    slope_q16       = 0;
    model_zero_span = 1'b0;
  endtask

  // apb write: setup phase, then access phase until pready, then idle
  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PEDAL_MIN:     cfg_shadow.pedal_min     = value[SAMPLE_W-1:0];
      REG_PEDAL_MAX:     cfg_shadow.pedal_max     = value[SAMPLE_W-1:0];
      REG_TPS_MIN:       cfg_shadow.tps_min       = value[SAMPLE_W-1:0];
      REG_TPS_MAX:       cfg_shadow.tps_max       = value[SAMPLE_W-1:0];
      REG_INITIAL_ANGLE: cfg_shadow.initial_angle = value[ANGLE_W-1:0];
      REG_SWEEP_REVERSE: cfg_shadow.sweep_reverse = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic config_all(int unsigned pmin, int unsigned pmax, int unsigned tmin,
                            int unsigned tmax, int unsigned init_ang, int unsigned rev);
    write_reg(REG_PEDAL_MIN, pmin);
    write_reg(REG_PEDAL_MAX, pmax);
    write_reg(REG_TPS_MIN, tmin);
    write_reg(REG_TPS_MAX, tmax);
    write_reg(REG_INITIAL_ANGLE, init_ang);
    write_reg(REG_SWEEP_REVERSE, rev);
  endtask

  // random settings, with a zero pedal span now and then
  task automatic shuffle_config();
    int unsigned pmin;
    int unsigned pmax;
    pmin = $urandom_range(SAMPLE_MAX);
    pmax = ($urandom_range(5) == 0) ? pmin : $urandom_range(SAMPLE_MAX);
    config_all(pmin, pmax, $urandom_range(SAMPLE_MAX, 1), $urandom_range(SAMPLE_MAX - 1),
               $urandom_range(ANGLE_REG_MAX), $urandom_range(1));
  endtask

  // offer one tick beat, with random gaps ahead of it; valid stays up for the next beat
  task automatic send_tick(bit func, int unsigned sample, int unsigned target);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= func;
    in_tps_sample      <= SAMPLE_W'(sample);
    in_target_position <= SAMPLE_W'(target);
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(servo_tick(func, SAMPLE_W'(sample), SAMPLE_W'(target)));
    ticks_sent++;
  endtask

  // stop offering and wait until every predicted command has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // full calibration: restart, sweep low, find low end, sweep high, find high end, run
  task automatic calibrate_and_run(int n_low, int n_high, int n_run);
    int unsigned lo;
    int unsigned hi;
    lo = cfg_shadow.tps_min;
    hi = cfg_shadow.tps_max;
    send_tick(FUNC_RESTART, $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
    repeat (n_low)
      send_tick(FUNC_TICK, $urandom_range(SAMPLE_MAX, lo), $urandom_range(SAMPLE_MAX));
    // a threshold at the rail can never be crossed, the sweep then just goes on
    if (lo > 0)
      send_tick(FUNC_TICK, $urandom_range(lo - 1, 0), $urandom_range(SAMPLE_MAX));
    repeat (n_high)
      send_tick(FUNC_TICK, $urandom_range(hi, 0), $urandom_range(SAMPLE_MAX));
    if (hi < SAMPLE_MAX)
      send_tick(FUNC_TICK, $urandom_range(SAMPLE_MAX, hi + 1), $urandom_range(SAMPLE_MAX));
    repeat (n_run)
      send_tick(FUNC_TICK, $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    // reset settings: sweep low from 90, tps_min of zero never ends it
    send_tick(FUNC_TICK, 0, 0);
    send_tick(FUNC_TICK, SAMPLE_MAX, SAMPLE_MAX);
    drain_results();
    // reversed direction from the top limit, thresholds at the far rails
    config_all(0, SAMPLE_MAX, SAMPLE_MAX, 0, ANGLE_HI, 1);
    send_tick(FUNC_RESTART, SAMPLE_MAX, SAMPLE_MAX);
    send_tick(FUNC_TICK, SAMPLE_MAX, 0);            // clamps at the top limit
    send_tick(FUNC_TICK, 0, 0);                     // low end found
    send_tick(FUNC_TICK, 0, 0);                     // one step toward high
    send_tick(FUNC_TICK, SAMPLE_MAX, 0);            // high end found, slope computed
    send_tick(FUNC_TICK, 0, 0);
    send_tick(FUNC_TICK, 0, SAMPLE_MAX);
    send_tick(FUNC_TICK, 0, 12'h555);
    send_tick(FUNC_TICK, SAMPLE_MAX, 12'haaa);
    drain_results();
    // zero pedal span, initial angle above the output range
    config_all(2048, 2048, 1, SAMPLE_MAX - 1, ANGLE_REG_MAX, 0);
    send_tick(FUNC_RESTART, 0, 0);                  // shown saturated
    send_tick(FUNC_TICK, 0, 0);                     // low end beyond 180
    send_tick(FUNC_TICK, SAMPLE_MAX, 0);            // span error raised
    send_tick(FUNC_TICK, 0, 0);
    send_tick(FUNC_TICK, 0, SAMPLE_MAX);
    send_tick(FUNC_RESTART, SAMPLE_MAX, SAMPLE_MAX); // span error cleared
    drain_results();
    // negative span, lower angle limit, mapped angle below zero
    config_all(SAMPLE_MAX, 0, 1, SAMPLE_MAX - 1, 0, 0);
    send_tick(FUNC_RESTART, 0, 0);
    send_tick(FUNC_TICK, SAMPLE_MAX, 0);            // clamps at the bottom limit
    send_tick(FUNC_TICK, 0, 0);
    send_tick(FUNC_TICK, SAMPLE_MAX, 0);            // high end below zero
    send_tick(FUNC_TICK, 0, 0);
    send_tick(FUNC_TICK, 0, SAMPLE_MAX);
    drain_results();
  endtask

  // mostly well-formed calibrations with random content, some raw noise
  task automatic test_random_traffic(int idle_pct, int stall_set, int n_ticks);
    int stop_at;
    send_idle_pct = idle_pct;
    stall_pct     = stall_set;
    stop_at       = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        shuffle_config();
      end
      if ($urandom_range(4) != 0)
        calibrate_and_run($urandom_range(6), $urandom_range(6), $urandom_range(12, 1));
      else
        repeat ($urandom_range(8, 1))
          send_tick($urandom_range(7) == 0, $urandom_range(SAMPLE_MAX),
                    $urandom_range(SAMPLE_MAX));
    end
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct     = 0;
    drain_results();
    shuffle_config();
    hold_req++;
    calibrate_and_run(3, 3, 30);
    drain_results();
  endtask

  // sender stops until every command is back, then resumes mid-run
  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    stall_pct     = 12;
    calibrate_and_run(2, 2, 5);
    drain_results();
    repeat ($urandom_range(12, 1))
      send_tick(FUNC_TICK, $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
    drain_results();
  endtask

  // receiver ready: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each result beat with the oldest predicted command
  always @(posedge clk) begin : check_results
    servo_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: result beat with nothing expected: angle %0d phase %0d span_error %0b",
                 $time, out_servo_angle, out_phase, out_span_error);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_servo_angle !== want.angle) begin
          $display("%0t: servo_angle expected %0d actual %0d", $time, want.angle,
                   out_servo_angle);
          errors++;
        end
        if (out_phase !== want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_phase);
          errors++;
        end
        if (out_span_error !== want.span_err) begin
          $display("%0t: span_error expected %0b actual %0b", $time, want.span_err,
                   out_span_error);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any beat moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
               stuck_cycles, pending_cmds.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(0, 0, 110);
    test_random_traffic(49, 0, 110);
    test_random_traffic(0, 49, 110);
    test_random_traffic(12, 12, 110);
    test_output_hold();
    test_pause_until_drained();

    // let any stray beat show up before the verdict
    stall_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_cmds.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_cmds.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
